// File: rtl/atv_pkg.sv
// ----------------------------------------------------------------------------
// atv_pkg
// Shared types, constants and helper functions for the tilt-to-velocity block.
// ----------------------------------------------------------------------------
`default_nettype none

package atv_pkg;

  localparam int HISTORY_DEPTH = 6;
  localparam int CORDIC_STEPS  = 16;
  localparam int ANGLE_TABLE_LEN = 24;

  // Square root on (b^2 + c^2) << 16: 54-bit operand, one result bit per step
  localparam int SQ_W       = 37;
  localparam int OP_W       = 54;
  localparam int ROOT_STEPS = OP_W / 2;
  localparam int ROOT_W     = ROOT_STEPS;
  localparam int REM_W      = ROOT_W + 3;

  localparam int CNT_MAX = (ROOT_STEPS > CORDIC_STEPS) ? ROOT_STEPS : CORDIC_STEPS;
  localparam int CNT_W   = $clog2(CNT_MAX);

  localparam int FILT_W = 19;  // 6 * 16-bit sample plus sign
  localparam int CORD_W = 32;

  // Register indexes on the configuration port
  localparam logic [2:0] REG_X_SRC    = 3'd0;
  localparam logic [2:0] REG_Y_SRC    = 3'd1;
  localparam logic [2:0] REG_Z_SRC    = 3'd2;
  localparam logic [2:0] REG_INVERT   = 3'd3;
  localparam logic [2:0] REG_LIN_GAIN = 3'd4;
  localparam logic [2:0] REG_ANG_GAIN = 3'd5;

  localparam logic [1:0] SRC_NONE = 2'd3;

  typedef struct packed {
    logic [1:0]         x_src;
    logic [1:0]         y_src;
    logic [1:0]         z_src;
    logic [2:0]         invert;
    logic signed [15:0] lin_gain;
    logic signed [15:0] ang_gain;
  } atv_cfg_t;

  typedef struct packed {
    logic             push;
    logic             filt;
    logic             sq1;
    logic             sq2;
    logic             root_step;
    logic             cord_init;
    logic             cord_step;
    logic             ang_store;
    logic             vel_fwd;
    logic             vel_turn;
    logic             out_load;
    logic             pass;
    logic [CNT_W-1:0] cnt;
  } atv_cmd_t;

  // atan(2^-i) in units of (pi/2) / 2^30
  function automatic logic [CORD_W-1:0] atan_lut(input logic [CNT_W-1:0] i);
    logic [CORD_W-1:0] v;
    case (i)
      5'd0:    v = 32'd536870912;
      5'd1:    v = 32'd316933406;
      5'd2:    v = 32'd167458907;
      5'd3:    v = 32'd85004756;
      5'd4:    v = 32'd42667331;
      5'd5:    v = 32'd21354465;
      5'd6:    v = 32'd10679838;
      5'd7:    v = 32'd5340245;
      5'd8:    v = 32'd2670163;
      5'd9:    v = 32'd1335087;
      5'd10:   v = 32'd667544;
      5'd11:   v = 32'd333772;
      5'd12:   v = 32'd166886;
      5'd13:   v = 32'd83443;
      5'd14:   v = 32'd41722;
      5'd15:   v = 32'd20861;
      5'd16:   v = 32'd10430;
      5'd17:   v = 32'd5215;
      5'd18:   v = 32'd2608;
      5'd19:   v = 32'd1304;
      5'd20:   v = 32'd652;
      5'd21:   v = 32'd326;
      5'd22:   v = 32'd163;
      5'd23:   v = 32'd81;
      default: v = '0;
    endcase
    return v;
  endfunction

  // Saturate an 18-bit signed value to 16 bits
  function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
    logic signed [15:0] r;
    if (v > 18'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -18'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: rtl/accel_tilt_to_velocity_top.sv
// ----------------------------------------------------------------------------
// accel_tilt_to_velocity_top
// Accelerometer tilt to forward/turn velocity: smoothing, pitch and roll by
// square root plus CORDIC, signed gain, with an APB register file.
// ----------------------------------------------------------------------------
//  Channel   Dir   Handshake               Payload
//  in        in    in_valid_i/in_ready_o   sample_a_i, sample_b_i, sample_c_i
//  out       out   out_valid_o/out_ready_i forward_velocity_o, turn_velocity_o,
//                                          pitch_norm_o, roll_norm_o
//  cfg       in    psel/penable/pwrite     paddr, pwdata, prdata, pready
//
//  A new transaction is accepted only once the last one has been loaded into
//  the output register; each takes two passes of a 27-step bit-serial square
//  root and a 16-step CORDIC on one shared unit, plus filter, square and
//  gain steps.
//  A finished result sits in the output register; the next transaction is
//  accepted meanwhile and only stalls at its own final step if still unread.
//  Reset clears the delay lines, the sequencer and the registers to defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module accel_tilt_to_velocity_top (
  input  wire                clk_i,
  input  wire                rst_ni,
  // input channel
  input  wire                in_valid_i,
  output logic               in_ready_o,
  input  wire  logic signed [15:0] sample_a_i,
  input  wire  logic signed [15:0] sample_b_i,
  input  wire  logic signed [15:0] sample_c_i,
  // result channel
  output logic               out_valid_o,
  input  wire                out_ready_i,
  output logic signed [15:0] forward_velocity_o,
  output logic signed [15:0] turn_velocity_o,
  output logic signed [15:0] pitch_norm_o,
  output logic signed [15:0] roll_norm_o,
  // configuration port
  input  wire                psel,
  input  wire                penable,
  input  wire                pwrite,
  input  wire  [4:0]         paddr,
  input  wire  [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import atv_pkg::*;

  atv_cfg_t cfg_q;
  atv_cmd_t cmd;
  logic     wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite;

  // Register file; the user is to write only while idle, which the block does not enforce, so no guarding here
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.x_src    <= 2'd0;
      cfg_q.y_src    <= 2'd1;
      cfg_q.z_src    <= 2'd2;
      cfg_q.invert   <= 3'd0;
      cfg_q.lin_gain <= 16'sd256;
      cfg_q.ang_gain <= 16'sd256;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_X_SRC:    cfg_q.x_src    <= pwdata[1:0];
        REG_Y_SRC:    cfg_q.y_src    <= pwdata[1:0];
        REG_Z_SRC:    cfg_q.z_src    <= pwdata[1:0];
        REG_INVERT:   cfg_q.invert   <= pwdata[2:0];
        REG_LIN_GAIN: cfg_q.lin_gain <= pwdata[15:0];
        REG_ANG_GAIN: cfg_q.ang_gain <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_X_SRC:    prdata = {30'b0, cfg_q.x_src};
      REG_Y_SRC:    prdata = {30'b0, cfg_q.y_src};
      REG_Z_SRC:    prdata = {30'b0, cfg_q.z_src};
      REG_INVERT:   prdata = {29'b0, cfg_q.invert};
      REG_LIN_GAIN: prdata = {16'b0, cfg_q.lin_gain};
      REG_ANG_GAIN: prdata = {16'b0, cfg_q.ang_gain};
      default:      prdata = '0;
    endcase
  end

  atv_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  atv_datapath u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .cfg_i              (cfg_q),
    .sample_a_i         (sample_a_i),
    .sample_b_i         (sample_b_i),
    .sample_c_i         (sample_c_i),
    .forward_velocity_o (forward_velocity_o),
    .turn_velocity_o    (turn_velocity_o),
    .pitch_norm_o       (pitch_norm_o),
    .roll_norm_o        (roll_norm_o)
  );

endmodule

`default_nettype wire

// File: rtl/atv_datapath.sv
// ----------------------------------------------------------------------------
// atv_datapath
// Delay lines, smoothing, shared square root and CORDIC units, gain and
// output registers.
// ----------------------------------------------------------------------------
`default_nettype none

module atv_datapath (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  atv_pkg::atv_cmd_t          cmd_i,
  input  atv_pkg::atv_cfg_t          cfg_i,
  input  wire  logic signed [15:0]   sample_a_i,
  input  wire  logic signed [15:0]   sample_b_i,
  input  wire  logic signed [15:0]   sample_c_i,
  output logic signed [15:0]         forward_velocity_o,
  output logic signed [15:0]         turn_velocity_o,
  output logic signed [15:0]         pitch_norm_o,
  output logic signed [15:0]         roll_norm_o
);
  import atv_pkg::*;

  logic signed [15:0] hx_q [HISTORY_DEPTH];
  logic signed [15:0] hy_q [HISTORY_DEPTH];
  logic signed [15:0] hz_q [HISTORY_DEPTH];

  logic signed [FILT_W-1:0] fx_q, fy_q, fz_q;
  logic signed [FILT_W-1:0] fx_d, fy_d, fz_d;
  logic signed [FILT_W-1:0] num, den_b;

  logic [SQ_W-1:0]   prod_q;
  logic [OP_W-1:0]   op_q;
  logic [REM_W-1:0]  rem_q;
  logic [ROOT_W-1:0] root_q;
  logic [REM_W-1:0]  rem_sh, trial;

  logic signed [CORD_W-1:0] xc_q, yc_q, z_q;
  logic signed [CORD_W-1:0] dx, dy, at;
  logic                     zero_q;

  logic signed [15:0] pitch_q, roll_q, fwd_q, turn_q, ang_d, vel_d;
  logic signed [CORD_W:0]   zsum;
  logic signed [31:0]       vprod;
  logic signed [32:0]       vsum;
  logic signed [2*FILT_W-1:0] sq_b, sq_c;

  function automatic logic signed [15:0] pick(input logic [1:0] sel,
                                              input logic signed [15:0] a,
                                              input logic signed [15:0] b,
                                              input logic signed [15:0] c);
    logic signed [15:0] r;
    case (sel)
      2'd0:     r = a;
      2'd1:     r = b;
      2'd2:     r = c;
      default:  r = '0;
    endcase
    return r;
  endfunction

  function automatic logic signed [FILT_W-1:0] smooth(input logic signed [15:0] h0,
                                                      input logic signed [15:0] h1,
                                                      input logic signed [15:0] h2,
                                                      input logic signed [15:0] h3);
    logic signed [FILT_W-1:0] s;
    s = FILT_W'(h0) + (FILT_W'(h1) <<< 1) + (FILT_W'(h2) <<< 1) + FILT_W'(h3);
    return s;
  endfunction

  // Delay lines: entry 0 oldest, cleared at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < HISTORY_DEPTH; i++) begin
        hx_q[i] <= '0;
        hy_q[i] <= '0;
        hz_q[i] <= '0;
      end
    end else if (cmd_i.push) begin
      for (int i = 0; i < HISTORY_DEPTH - 1; i++) begin
        hx_q[i] <= hx_q[i+1];
        hy_q[i] <= hy_q[i+1];
        hz_q[i] <= hz_q[i+1];
      end
      hx_q[HISTORY_DEPTH-1] <= pick(cfg_i.x_src, sample_a_i, sample_b_i, sample_c_i);
      hy_q[HISTORY_DEPTH-1] <= pick(cfg_i.y_src, sample_a_i, sample_b_i, sample_c_i);
      hz_q[HISTORY_DEPTH-1] <= pick(cfg_i.z_src, sample_a_i, sample_b_i, sample_c_i);
    end
  end

  always_comb begin
    fx_d = smooth(hx_q[0], hx_q[1], hx_q[2], hx_q[3]);
    fy_d = smooth(hy_q[0], hy_q[1], hy_q[2], hy_q[3]);
    fz_d = smooth(hz_q[0], hz_q[1], hz_q[2], hz_q[3]);
    if (cfg_i.invert[0]) fx_d = -fx_d;
    if (cfg_i.invert[1]) fy_d = -fy_d;
    if (cfg_i.invert[2]) fz_d = -fz_d;
  end

  // Pass 0 is pitch (x over y,z), pass 1 is roll (y over x,z)
  assign num   = cmd_i.pass ? fy_q : fx_q;
  assign den_b = cmd_i.pass ? fx_q : fy_q;
  assign sq_b  = den_b * den_b;
  assign sq_c  = fz_q * fz_q;

  // Square root: two operand bits per step
  assign rem_sh = {rem_q[REM_W-3:0], op_q[OP_W-1 -: 2]};
  assign trial  = {1'b0, root_q, 2'b01};

  // CORDIC vectoring step
  assign dx = yc_q >>> cmd_i.cnt;
  assign dy = xc_q >>> cmd_i.cnt;
  assign at = atan_lut(cmd_i.cnt);

  assign zsum  = {z_q[CORD_W-1], z_q} + (CORD_W+1)'(16384);
  assign ang_d = zero_q ? 16'sd0 : sat16(zsum[CORD_W:15]);

  assign vprod = cmd_i.vel_fwd ? pitch_q * cfg_i.lin_gain : roll_q * cfg_i.ang_gain;
  assign vsum  = {vprod[31], vprod} + 33'sd16384;
  assign vel_d = sat16(vsum[32:15]);

  always_ff @(posedge clk_i) begin
    if (cmd_i.filt) begin
      fx_q <= fx_d;
      fy_q <= fy_d;
      fz_q <= fz_d;
    end
    if (cmd_i.sq1) begin
      prod_q <= sq_b[SQ_W-1:0];
    end
    if (cmd_i.sq2) begin
      op_q   <= {{(OP_W-SQ_W-16){1'b0}}, prod_q + sq_c[SQ_W-1:0], 16'b0};
      rem_q  <= '0;
      root_q <= '0;
    end
    if (cmd_i.root_step) begin
      op_q <= op_q << 2;
      if (rem_sh >= trial) begin
        rem_q  <= rem_sh - trial;
        root_q <= {root_q[ROOT_W-2:0], 1'b1};
      end else begin
        rem_q  <= rem_sh;
        root_q <= {root_q[ROOT_W-2:0], 1'b0};
      end
    end
    if (cmd_i.cord_init) begin
      xc_q   <= CORD_W'(root_q);
      // numerator times 256, sign carried into the upper bits
      yc_q   <= {{(CORD_W-FILT_W-8){num[FILT_W-1]}}, num, 8'b0};
      z_q    <= '0;
      zero_q <= (root_q == '0) && (num == '0);
    end
    if (cmd_i.cord_step) begin
      if (yc_q > 0) begin
        xc_q <= xc_q + dx;
        yc_q <= yc_q - dy;
        z_q  <= z_q + at;
      end else begin
        xc_q <= xc_q - dx;
        yc_q <= yc_q + dy;
        z_q  <= z_q - at;
      end
    end
    if (cmd_i.ang_store) begin
      if (cmd_i.pass) roll_q <= ang_d;
      else            pitch_q <= ang_d;
    end
    if (cmd_i.vel_fwd)  fwd_q  <= vel_d;
    if (cmd_i.vel_turn) turn_q <= vel_d;
    if (cmd_i.out_load) begin
      forward_velocity_o <= fwd_q;
      turn_velocity_o    <= turn_q;
      pitch_norm_o       <= pitch_q;
      roll_norm_o        <= roll_q;
    end
  end

endmodule

`default_nettype wire

// File: rtl/atv_ctrl.sv
// ----------------------------------------------------------------------------
// atv_ctrl
// Sequencer: walks one transaction through filter, root, CORDIC and gain.
// ----------------------------------------------------------------------------
`default_nettype none

module atv_ctrl (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  wire                out_ready_i,
  output atv_pkg::atv_cmd_t  cmd_o
);
  import atv_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_FILT  = 4'd1;
  localparam logic [3:0] S_SQ1   = 4'd2;
  localparam logic [3:0] S_SQ2   = 4'd3;
  localparam logic [3:0] S_ROOT  = 4'd4;
  localparam logic [3:0] S_CINIT = 4'd5;
  localparam logic [3:0] S_CORD  = 4'd6;
  localparam logic [3:0] S_ANG   = 4'd7;
  localparam logic [3:0] S_VEL1  = 4'd8;
  localparam logic [3:0] S_VEL2  = 4'd9;
  localparam logic [3:0] S_OUT   = 4'd10;

  logic [3:0]       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             pass_q, pass_d;
  logic             out_valid_q, out_valid_d;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    pass_d      = pass_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    cmd_o.pass  = pass_q;
    cmd_o.cnt   = cnt_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.push = 1'b1;
          state_d    = S_FILT;
        end
      end
      S_FILT: begin
        cmd_o.filt = 1'b1;
        pass_d     = 1'b0;
        state_d    = S_SQ1;
      end
      S_SQ1: begin
        cmd_o.sq1 = 1'b1;
        state_d   = S_SQ2;
      end
      S_SQ2: begin
        cmd_o.sq2 = 1'b1;
        cnt_d     = '0;
        state_d   = S_ROOT;
      end
      S_ROOT: begin
        cmd_o.root_step = 1'b1;
        if (cnt_q == CNT_W'(ROOT_STEPS - 1)) begin
          cnt_d   = '0;
          state_d = S_CINIT;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_CINIT: begin
        cmd_o.cord_init = 1'b1;
        state_d         = S_CORD;
      end
      S_CORD: begin
        cmd_o.cord_step = 1'b1;
        if (cnt_q == CNT_W'(CORDIC_STEPS - 1)) begin
          cnt_d   = '0;
          state_d = S_ANG;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_ANG: begin
        cmd_o.ang_store = 1'b1;
        if (!pass_q) begin
          pass_d  = 1'b1;
          state_d = S_SQ1;
        end else begin
          state_d = S_VEL1;
        end
      end
      S_VEL1: begin
        cmd_o.vel_fwd = 1'b1;
        state_d       = S_VEL2;
      end
      S_VEL2: begin
        cmd_o.vel_turn = 1'b1;
        state_d        = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      pass_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      pass_q      <= pass_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Output register is only refilled once the waiting result has gone
  a_out_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (!out_valid_q || out_ready_i))
    else $error("result overwritten before being taken");

  // A new transaction is never taken while one is still in flight
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("second transaction accepted while busy");

  // CORDIC counter stays within the angle table
  a_cord_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.cord_step |-> (cnt_q < CNT_W'(CORDIC_STEPS)))
    else $error("CORDIC step counter out of range");

  // Roll angle is only stored on the second pass, straight before the gains
  a_roll_then_vel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.ang_store && pass_q) |=> cmd_o.vel_fwd)
    else $error("gain stage not entered after roll");

endmodule

`default_nettype wire

// File: tb/accel_tilt_to_velocity_top_tb.sv
// ----------------------------------------------------------------------------
// accel_tilt_to_velocity_top_tb
// Self-checking bench: queue-fed driver and monitor, own tilt/velocity
// predictor, register phases via APB, random idling and back-pressure.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module accel_tilt_to_velocity_top_tb;
  import atv_pkg::*;

  typedef struct {
    logic signed [15:0] a, b, c;
  } accel_sample_t;

  typedef struct {
    logic signed [15:0] fwd, turn, pitch, roll;
  } tilt_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic signed [15:0] sample_a_i = '0, sample_b_i = '0, sample_c_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [15:0] forward_velocity_o, turn_velocity_o, pitch_norm_o, roll_norm_o;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  accel_tilt_to_velocity_top dut (.*);

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Stimulus and scoreboard state
  accel_sample_t sample_q[$];
  tilt_result_t  expected_q[$];
  int            errors = 0;
  int            send_idle_pct = 0;
  int            recv_idle_pct = 0;
  int            phase = -1;
  logic          hold_off = 1'b0;   // long receiver stall, own process below

  // Predictor copies of the state and registers
  int signed   x_hist[HISTORY_DEPTH], y_hist[HISTORY_DEPTH], z_hist[HISTORY_DEPTH];
  logic [1:0]  sel_x = 2'd0, sel_y = 2'd1, sel_z = 2'd2;
  logic [2:0]  neg_mask = '0;
  logic signed [15:0] gain_lin = 16'sd256, gain_ang = 16'sd256;

  function automatic longint asr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint clip16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic longint int_root(longint unsigned n);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return longint'(res);
  endfunction

  // atan2(num, sqrt(p^2 + q^2)) over pi/2, Q1.15
  function automatic longint tilt_q15(longint num, longint p, longint q);
    longint xc, yc, acc, dx, dy;
    longint unsigned sq;
    longint atans[16] = '{536870912, 316933406, 167458907, 85004756, 42667331,
                          21354465, 10679838, 5340245, 2670163, 1335087, 667544,
                          333772, 166886, 83443, 41722, 20861};
    sq = longint'(p * p) + longint'(q * q);
    xc = int_root(sq << 16);
    yc = num * 256;
    acc = 0;
    if (xc == 0 && yc == 0) return 0;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = asr(yc, i);
      dy = asr(xc, i);
      if (yc > 0) begin
        xc += dx; yc -= dy; acc += atans[i];
      end else begin
        xc -= dx; yc += dy; acc -= atans[i];
      end
    end
    return clip16(asr(acc + 16384, 15));
  endfunction

  function automatic int signed route(logic [1:0] s, accel_sample_t t);
    case (s)
      2'd0:    return t.a;
      2'd1:    return t.b;
      2'd2:    return t.c;
      default: return 0;
    endcase
  endfunction

  task automatic predict_tilt(accel_sample_t t);
    longint fx, fy, fz, pitch, roll;
    tilt_result_t r;
    for (int i = 0; i < HISTORY_DEPTH - 1; i++) begin
      x_hist[i] = x_hist[i+1]; y_hist[i] = y_hist[i+1]; z_hist[i] = z_hist[i+1];
    end
    x_hist[HISTORY_DEPTH-1] = route(sel_x, t);
    y_hist[HISTORY_DEPTH-1] = route(sel_y, t);
    z_hist[HISTORY_DEPTH-1] = route(sel_z, t);
    // 1-2-2-1 on the four oldest taps; the /6 cancels in the ratios
    fx = x_hist[0] + 2 * x_hist[1] + 2 * x_hist[2] + x_hist[3];
    fy = y_hist[0] + 2 * y_hist[1] + 2 * y_hist[2] + y_hist[3];
    fz = z_hist[0] + 2 * z_hist[1] + 2 * z_hist[2] + z_hist[3];
    if (neg_mask[0]) fx = -fx;
    if (neg_mask[1]) fy = -fy;
    if (neg_mask[2]) fz = -fz;
    pitch = tilt_q15(fx, fy, fz);
    roll  = tilt_q15(fy, fx, fz);
    r.pitch = pitch[15:0];
    r.roll  = roll[15:0];
    r.fwd   = 16'(clip16(asr(pitch * longint'(gain_lin) + 16384, 15)));
    r.turn  = 16'(clip16(asr(roll * longint'(gain_ang) + 16384, 15)));
    expected_q.insert(expected_q.size(), r);
  endtask

  // Driver: predicts at acceptance so register state matches the transaction
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        predict_tilt(sample_q.pop_front());
      end
      if (!(in_valid_i && !in_ready_o)) begin
        if (sample_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid_i <= 1'b1;
          sample_a_i <= sample_q[0].a;
          sample_b_i <= sample_q[0].b;
          sample_c_i <= sample_q[0].c;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor and receiver back-pressure
  always @(posedge clk_i) begin
    tilt_result_t e;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (expected_q.size() == 0) begin
          $error("unexpected result transaction");
          errors++;
        end else begin
          e = expected_q.pop_front();
          if (forward_velocity_o !== e.fwd) begin
            $error("forward_velocity exp %0d got %0d", e.fwd, forward_velocity_o);
            errors++;
          end
          if (turn_velocity_o !== e.turn) begin
            $error("turn_velocity exp %0d got %0d", e.turn, turn_velocity_o);
            errors++;
          end
          if (pitch_norm_o !== e.pitch) begin
            $error("pitch_norm exp %0d got %0d", e.pitch, pitch_norm_o);
            errors++;
          end
          if (roll_norm_o !== e.roll) begin
            $error("roll_norm exp %0d got %0d", e.roll, roll_norm_o);
            errors++;
          end
        end
      end
      if (hold_off) begin
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Long receiver hold-off in phase 6 while the sender keeps offering
  initial begin
    wait (phase == 6);
    @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (2000) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  // APB write: setup then access; pready is tied high
  task automatic reg_write(logic [2:0] idx, logic [31:0] val);
    @(posedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_X_SRC:    sel_x = val[1:0];
      REG_Y_SRC:    sel_y = val[1:0];
      REG_Z_SRC:    sel_z = val[1:0];
      REG_INVERT:   neg_mask = val[2:0];
      REG_LIN_GAIN: gain_lin = val[15:0];
      REG_ANG_GAIN: gain_ang = val[15:0];
      default: ;
    endcase
  endtask

  // Wait until every transaction has gone through and been checked
  task automatic drain();
    while (sample_q.size() != 0 || in_valid_i || expected_q.size() != 0) @(posedge clk_i);
    repeat (120) @(posedge clk_i);
  endtask

  task automatic queue_sample(int a, int b, int c);
    accel_sample_t t;
    t.a = a; t.b = b; t.c = c;
    sample_q.insert(sample_q.size(), t);
  endtask

  function automatic int rnd16();
    case ($urandom_range(5))
      0:       return $urandom_range(1) ? 32767 : -32768;
      1:       return int'($urandom_range(64)) - 32;
      default: return int'(16'($urandom));
    endcase
  endfunction

  task automatic queue_random(int n);
    int a, b, c;
    for (int k = 0; k < n; k++) begin
      a = rnd16(); b = rnd16(); c = rnd16();
      // steady runs give a settled filter and real tilts
      repeat ($urandom_range(1) ? $urandom_range(1, 8) : 1) queue_sample(a, b, c);
    end
  endtask

  task automatic set_regs(int xs, int ys, int zs, int inv, int lg, int ag);
    reg_write(REG_X_SRC, xs);
    reg_write(REG_Y_SRC, ys);
    reg_write(REG_Z_SRC, zs);
    reg_write(REG_INVERT, inv);
    reg_write(REG_LIN_GAIN, 32'(lg));
    reg_write(REG_ANG_GAIN, 32'(ag));
  endtask

  initial begin
    for (int i = 0; i < HISTORY_DEPTH; i++) begin
      x_hist[i] = 0; y_hist[i] = 0; z_hist[i] = 0;
    end
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed: early items with zero taps, zero vector, full tilt, extremes
    queue_sample(0, 0, 0);
    queue_sample(32767, 0, 0);
    repeat (6) queue_sample(32767, 0, 0);
    repeat (5) queue_sample(-32768, -32768, -32768);
    repeat (5) queue_sample(0, 32767, 0);
    queue_sample(-1, 1, -32768);
    queue_sample(12345, -6789, 1000);
    drain();
    // Gain overflow and unused select
    set_regs(3, 1, 3, 0, -32768, -32768);
    repeat (6) queue_sample(-32768, -32768, 5);
    drain();

    // Random phases over several settings, extremes included
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: set_regs(0, 1, 2, 0, 256, 256);
        1: set_regs(2, 0, 1, 7, 32767, -32768);
        2: set_regs(1, 2, 0, 5, -32768, 32767);
        3: set_regs(3, 3, 3, 2, 0, 0);
        default: set_regs($urandom_range(3), $urandom_range(3), $urandom_range(3),
                          $urandom_range(7), int'(16'($urandom)), int'(16'($urandom)));
      endcase
      send_idle_pct = (ph < 3) ? 17 : (ph < 6) ? 79 : 0;
      recv_idle_pct = (ph < 3) ? 79 : (ph < 6) ? 17 : 0;
      phase = ph;
      queue_random(77);
      drain();   // sender pause until all results are back
    end

    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #40ms;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// File: sim.f
rtl/atv_pkg.sv
rtl/atv_datapath.sv
rtl/atv_ctrl.sv
rtl/accel_tilt_to_velocity_top.sv
tb/accel_tilt_to_velocity_top_tb.sv
